@@ hw/rtl/scd_pkg.sv @@
// ----------------------------------------------------------------------------
// scd_pkg: shared types and constants of the sync and checksum deframer
//
// Holds the frame layout, the capture map, the register indexes and the
// structs that pass between the front end, the frame queue and the back end.
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int BYTE_W          = 8;
    localparam int NUM_CAPTURED    = 12;
    localparam int SLOT_W          = 4;
    localparam int POS_MAX_W       = 6;
    localparam int DEF_FRAME_BYTES = 47;
    localparam int QUEUE_DEPTH     = 2;
    localparam int CFG_ADDR_W      = 1;
    localparam int CFG_DATA_W      = 8;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 16;

    // Reset values of the sync registers.
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'h55;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'h13;

    // Field number of the final beat of a run.
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_CAPTURED - 1);

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SYNC_FIRST  = 1'b0,
        REG_SYNC_SECOND = 1'b1
    } cfg_reg_t;

    // The twelve captured payload bytes of one frame.
    typedef logic [NUM_CAPTURED-1:0][BYTE_W-1:0] cap_frame_t;

    // Status of the frame queue as seen by both sides.
    typedef struct packed {
        logic full;
        logic not_empty;
    } q_status_t;

    // Result of the capture map lookup.
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } cap_slot_t;

    // Maps a frame byte position to its capture slot, if it has one.
    function automatic cap_slot_t capture_slot(input logic [POS_MAX_W-1:0] pos);
        cap_slot_t res;
        res.hit  = 1'b1;
        res.slot = '0;
        unique case (pos)
            6'd2:  res.slot = 4'd0;
            6'd6:  res.slot = 4'd1;
            6'd7:  res.slot = 4'd2;
            6'd9:  res.slot = 4'd3;
            6'd10: res.slot = 4'd4;
            6'd14: res.slot = 4'd5;
            6'd15: res.slot = 4'd6;
            6'd16: res.slot = 4'd7;
            6'd17: res.slot = 4'd8;
            6'd18: res.slot = 4'd9;
            6'd19: res.slot = 4'd10;
            6'd20: res.slot = 4'd11;
            default: res.hit = 1'b0;
        endcase
        return res;
    endfunction

endpackage

@@ hw/rtl/sync_checksum_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// sync_checksum_frame_deframer: sync hunt and checksum frame deframer
//
// Input stream: one received byte per beat on s_tdata[7:0]. The block hunts
// for the first sync byte directly followed by the second one, then counts a
// frame of FRAME_BYTES bytes (the sync bytes are bytes 0 and 1). An 8-bit
// wrapping sum runs over all bytes but the last; the last byte is the
// checksum. Bytes 2, 6, 7, 9, 10 and 14 to 20 are captured.
// Output stream: for a frame whose checksum matches, twelve beats carry the
// captured bytes with their field number; m_tlast marks the twelfth. A frame
// that fails is dropped without output and the hunt restarts.
// Throughput: one input byte per cycle unless s_tready is low. A checked frame
// is queued, loaded by the run sender and sent one beat per cycle unless stalled.
// A two-entry frame queue sits between the hunt logic and the run sender;
// s_tready drops only while both entries are full, so a stalled receiver
// holds back input only once three complete runs are pending (one in the
// run sender and two in the queue).
// Configuration: cfg_addr 0 writes the first sync byte, 1 the second; writes
// take effect on the next cycle. Reset restores 0x55 and 0x13, empties the
// queue and restarts the hunt.
// ----------------------------------------------------------------------------
module sync_checksum_frame_deframer #(
    parameter int FRAME_BYTES = scd_pkg::DEF_FRAME_BYTES
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Input stream; s_tdata: [7:0] rx_byte.
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [scd_pkg::S_TDATA_W-1:0]     s_tdata,
    // Result stream; m_tdata: [7:0] field_value, [11:8] field_number,
    // [15:12] zero. m_tlast: last_of_frame.
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [scd_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tlast,
    // Configuration write port.
    input  logic                              cfg_wr_en,
    input  logic [scd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [scd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import scd_pkg::*;

    logic [BYTE_W-1:0]  sync_first_reg;
    logic [BYTE_W-1:0]  sync_second_reg;
    q_status_t          q_stat;
    logic               push_valid;
    cap_frame_t         push_frame;
    cap_frame_t         rd_frame;
    logic               pop;
    logic [BYTE_W-1:0]  field_value;
    logic [SLOT_W-1:0]  field_number;

    // Sync byte registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SYNC_FIRST:  sync_first_reg  <= cfg_wdata[BYTE_W-1:0];
                REG_SYNC_SECOND: sync_second_reg <= cfg_wdata[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    scd_front #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .rx_byte     (s_tdata[BYTE_W-1:0]),
        .sync_first  (sync_first_reg),
        .sync_second (sync_second_reg),
        .q_stat      (q_stat),
        .push_valid  (push_valid),
        .push_frame  (push_frame)
    );

    scd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_frame (push_frame),
        .pop        (pop),
        .q_stat     (q_stat),
        .rd_frame   (rd_frame)
    );

    scd_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .rd_frame      (rd_frame),
        .pop           (pop),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .field_value   (field_value),
        .field_number  (field_number),
        .last_of_frame (m_tlast)
    );

    // Pack the result beat, padding to whole bytes.
    assign m_tdata = {{(M_TDATA_W - BYTE_W - SLOT_W){1'b0}}, field_number, field_value};

endmodule

@@ hw/rtl/scd_front.sv @@
// ----------------------------------------------------------------------------
// scd_front: sync hunt, frame count, checksum and byte capture
//
// Takes one received byte per beat, hunts for the two sync bytes, keeps the
// running sum over a frame and hands a frame that passes its checksum to the
// queue as twelve captured bytes.
// ----------------------------------------------------------------------------
module scd_front #(
    parameter int FRAME_BYTES = scd_pkg::DEF_FRAME_BYTES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [scd_pkg::BYTE_W-1:0]     rx_byte,
    input  logic [scd_pkg::BYTE_W-1:0]     sync_first,
    input  logic [scd_pkg::BYTE_W-1:0]     sync_second,
    input  scd_pkg::q_status_t             q_stat,
    output logic                           push_valid,
    output scd_pkg::cap_frame_t            push_frame
);
    import scd_pkg::*;

    localparam int              POS_W    = $clog2(FRAME_BYTES);
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] DATA_POS = POS_W'(2);

    typedef enum logic [2:0] {
        PH_HUNT  = 3'b001,
        PH_SYNC1 = 3'b010,
        PH_FRAME = 3'b100
    } phase_t;

    phase_t             phase_reg, phase_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BYTE_W-1:0]  sum_reg, sum_next;
    cap_frame_t         cap_reg, cap_next;
    cap_slot_t          slot;
    logic               accept;

    // A byte is taken whenever the queue can hold another frame.
    assign s_tready = !q_stat.full;
    assign accept   = s_tvalid && s_tready;
    assign slot     = capture_slot(POS_MAX_W'(pos_reg));

    // Hunt and frame state machine.
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        sum_next   = sum_reg;
        cap_next   = cap_reg;
        push_valid = 1'b0;
        if (accept) begin
            unique case (phase_reg)
                PH_SYNC1: begin
                    if (rx_byte == sync_second) begin
                        phase_next = PH_FRAME;
                        pos_next   = DATA_POS;
                        sum_next   = sync_first + rx_byte;
                    end else if (rx_byte == sync_first) begin
                        phase_next = PH_SYNC1;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_FRAME: begin
                    if (slot.hit) begin
                        cap_next[slot.slot] = rx_byte;
                    end
                    if (pos_reg >= LAST_POS) begin
                        // Checksum byte: hand over the frame on a match.
                        push_valid = (rx_byte == sum_reg);
                        phase_next = PH_HUNT;
                        pos_next   = '0;
                    end else begin
                        sum_next = sum_reg + rx_byte;
                        pos_next = pos_reg + POS_W'(1);
                    end
                end
                default: begin
                    phase_next = (rx_byte == sync_first) ? PH_SYNC1 : PH_HUNT;
                end
            endcase
        end
    end

    // The current byte is merged in, so a capture at the checksum byte counts.
    assign push_frame = cap_next;

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HUNT;
            pos_reg   <= '0;
            sum_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            sum_reg   <= sum_next;
        end
    end

    // Captured payload bytes.
    always_ff @(posedge aclk) begin
        cap_reg <= cap_next;
    end

endmodule

@@ hw/rtl/scd_queue.sv @@
// ----------------------------------------------------------------------------
// scd_queue: short queue of checked frames
//
// Holds captured frames between the front end and the back end so that the
// front end keeps taking bytes while the back end sends a run.
// ----------------------------------------------------------------------------
module scd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    input  scd_pkg::cap_frame_t  push_frame,
    input  logic                 pop,
    output scd_pkg::q_status_t   q_stat,
    output scd_pkg::cap_frame_t  rd_frame
);
    import scd_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cap_frame_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign q_stat.full      = (count_reg == CNT_W'(DEPTH));
    assign q_stat.not_empty = (count_reg != '0);
    assign do_push          = push_valid && !q_stat.full;
    assign do_pop           = pop && q_stat.not_empty;
    assign rd_frame         = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Frame storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

@@ hw/rtl/scd_back.sv @@
// ----------------------------------------------------------------------------
// scd_back: run sender
//
// Loads one checked frame from the queue and sends its twelve captured bytes
// as a run of beats, marking the last one.
// ----------------------------------------------------------------------------
module scd_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  scd_pkg::q_status_t             q_stat,
    input  scd_pkg::cap_frame_t            rd_frame,
    output logic                           pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [scd_pkg::BYTE_W-1:0]     field_value,
    output logic [scd_pkg::SLOT_W-1:0]     field_number,
    output logic                           last_of_frame
);
    import scd_pkg::*;

    logic                busy_reg, busy_next;
    logic [SLOT_W-1:0]   idx_reg, idx_next;
    cap_frame_t          frame_reg;
    logic                beat_done, run_done;

    assign m_tvalid      = busy_reg;
    assign field_value   = frame_reg[idx_reg];
    assign field_number  = idx_reg;
    assign last_of_frame = (idx_reg == LAST_SLOT);

    assign beat_done = m_tvalid && m_tready;
    assign run_done  = beat_done && last_of_frame;
    // Load the next frame as soon as the previous run has gone out.
    assign pop       = q_stat.not_empty && (!busy_reg || run_done);

    always_comb begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop) begin
            busy_next = 1'b1;
            idx_next  = '0;
        end else if (run_done) begin
            busy_next = 1'b0;
        end else if (beat_done) begin
            idx_next = idx_reg + SLOT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            frame_reg <= rd_frame;
        end
    end

endmodule

@@ hw/rtl/scd_checker.sv @@
// ----------------------------------------------------------------------------
// scd_checker: port-level checks of the deframer result stream
//
// Watches the result stream of the top level and checks run numbering,
// end-of-run marking, padding and beat stability under back-pressure.
// ----------------------------------------------------------------------------
module scd_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [scd_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tlast
);
    import scd_pkg::*;

    // A stalled beat keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // The end-of-run mark sits exactly on the twelfth field.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[11:8] == LAST_SLOT)))
        else $error("m_tlast does not match field number");

    // Inside a run the next beat follows at once with the next field number.
    a_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && (m_tdata[11:8] == $past(m_tdata[11:8]) + 4'd1))
        else $error("run field numbering broken");

    // Pad bits of the result beat stay zero.
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[15:12] == 4'd0))
        else $error("result pad bits not zero");

endmodule

bind sync_checksum_frame_deframer scd_checker u_scd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
